### hw/rtl/gaussian_blur_3x3_border_renorm_defines.svh
// Assertion macros for the 3x3 blur block.
`ifndef GAUSSIAN_BLUR_3X3_BORDER_RENORM_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_BORDER_RENORM_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define GB3_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define GB3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gb3_pkg.sv
// Constants, types and tap tables for the 3x3 blur block.
package gb3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int RING_SIZE = 2 * MAX_WIDTH + 4;
    localparam int ADDR_W    = $clog2(RING_SIZE);
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 13;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = HEIGHT_W;
    localparam int CNT_W     = 24;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int SUM_W     = 18;
    localparam int WSUM_W    = 10;
    localparam int TAPS      = 9;
    localparam int TAP_W     = 4;
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = 3;

    localparam logic [CH_W-1:0] W_CORNER = 8'd59;
    localparam logic [CH_W-1:0] W_EDGE   = 8'd97;
    localparam logic [CH_W-1:0] W_CENTER = 8'd159;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } off_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_READ   = 6'b000100,
        S_LAST   = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    function automatic logic [CH_W-1:0] tap_weight(input logic [TAP_W-1:0] k);
        logic [CH_W-1:0] w;
        case (k) inside
            4'd4:                   w = W_CENTER;
            4'd1, 4'd3, 4'd5, 4'd7: w = W_EDGE;
            default:                w = W_CORNER;
        endcase
        return w;
    endfunction

    function automatic off_t tap_row(input logic [TAP_W-1:0] k);
        off_t r;
        case (k) inside
            [4'd0:4'd2]: r = OFF_NEG;
            [4'd3:4'd5]: r = OFF_ZERO;
            default:     r = OFF_POS;
        endcase
        return r;
    endfunction

    function automatic off_t tap_col(input logic [TAP_W-1:0] k);
        off_t c;
        case (k) inside
            4'd0, 4'd3, 4'd6: c = OFF_NEG;
            4'd1, 4'd4, 4'd7: c = OFF_ZERO;
            default:          c = OFF_POS;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/gaussian_blur_3x3_border_renorm.sv
// A word that completes a window holds the input through S_DECIDE, S_READ (nine taps
// through the one read port of the ring memory), S_LAST, S_DIV (an 8-step divider per
// channel) and S_OUT, which waits until the output is free; other words only S_DECIDE.
// Reset (aresetn, synchronous): counters cleared, width 640, height 480.
// The ring memory needs no clearing; taps outside the frame are read but not accumulated.
`include "gaussian_blur_3x3_border_renorm_defines.svh"

module gaussian_blur_3x3_border_renorm
    import gb3_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PIX_W-1:0]    s_tdata,   // in_red, in_green, in_blue
    input  logic                s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PIX_W-1:0]    m_tdata,   // out_red, out_green, out_blue
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HEIGHT_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  w_eff_reg, w_eff_next;
    logic [HEIGHT_W-1:0] h_eff_reg, h_eff_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic [ADDR_W-1:0]   in_ptr_reg, in_ptr_next;
    logic [ADDR_W-1:0]   out_ptr_reg, out_ptr_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic                pix_taken_reg, pix_taken_next;
    logic [TAP_W-1:0]    k_reg, k_next;
    logic                tap_vld_reg, tap_vld_next;
    logic                tap_ok_reg, tap_ok_next;
    logic [TAP_W-1:0]    tap_k_reg, tap_k_next;
    logic [STEP_W-1:0]   div_step_reg, div_step_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [SUM_W-1:0]    acc_reg [NUM_CH];
    logic [SUM_W-1:0]    acc_next [NUM_CH];
    logic [CH_W-1:0]     q_reg [NUM_CH];
    logic [CH_W-1:0]     q_next [NUM_CH];
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [PIX_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                m_tlast_reg, m_tlast_next;

    logic [PIX_W-1:0]    mem [RING_SIZE];
    logic [PIX_W-1:0]    rd_data_reg;
    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    logic                accept;
    logic                pix_ok;
    logic                out_free;
    logic                out_last;
    logic [14:0]         a_sum;
    logic                row_ok;
    logic                col_ok;
    logic [WIDTH_W-1:0]  w_raw;
    logic [WIDTH_W-1:0]  w_new;
    logic [HEIGHT_W-1:0] h_new;
    logic [CNT_W-1:0]    lag;
    logic [2*CH_W-1:0]   prod [NUM_CH];
    logic [SUM_W-1:0]    dvs;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign accept   = s_tvalid && s_tready;
    assign pix_ok   = (s_tuser == FUNC_PIXEL) && (in_cnt_reg < total_reg);
    assign wr_en    = accept && pix_ok;
    assign rd_en    = (state_reg == S_READ);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_last = (out_cnt_reg + CNT_W'(1)) >= total_reg;
    assign lag      = in_cnt_reg - out_cnt_reg;
    assign dvs      = SUM_W'(wsum_reg) << div_step_reg;

    // ring address of the current tap and its border test
    always_comb begin
        a_sum = 15'(out_ptr_reg) + 15'(RING_SIZE);
        row_ok = 1'b1;
        col_ok = 1'b1;
        case (tap_row(k_reg))
            OFF_NEG: begin
                a_sum  = a_sum - 15'(w_eff_reg);
                row_ok = (out_row_reg != '0);
            end
            OFF_POS: begin
                a_sum  = a_sum + 15'(w_eff_reg);
                row_ok = (out_row_reg != (h_eff_reg - HEIGHT_W'(1)));
            end
            default: ;
        endcase
        case (tap_col(k_reg))
            OFF_NEG: begin
                a_sum  = a_sum - 15'(1);
                col_ok = (out_col_reg != '0);
            end
            OFF_POS: begin
                a_sum  = a_sum + 15'(1);
                col_ok = (WIDTH_W'(out_col_reg) != (w_eff_reg - WIDTH_W'(1)));
            end
            default: ;
        endcase
        if (a_sum >= 15'(2 * RING_SIZE)) begin
            rd_addr = ADDR_W'(a_sum - 15'(2 * RING_SIZE));
        end else if (a_sum >= 15'(RING_SIZE)) begin
            rd_addr = ADDR_W'(a_sum - 15'(RING_SIZE));
        end else begin
            rd_addr = ADDR_W'(a_sum);
        end
    end

    always_comb begin
        w_raw = cfg_wdata[WIDTH_W-1:0];
        if (w_raw == '0) begin
            w_new = WIDTH_W'(1);
        end else if (w_raw > WIDTH_W'(MAX_WIDTH)) begin
            w_new = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_new = w_raw;
        end
        h_new = (cfg_wdata == '0) ? HEIGHT_W'(1) : cfg_wdata;
    end

    always_comb begin
        state_next     = state_reg;
        w_eff_next     = w_eff_reg;
        h_eff_next     = h_eff_reg;
        total_next     = total_reg;
        in_cnt_next    = in_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        in_ptr_next    = in_ptr_reg;
        out_ptr_next   = out_ptr_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        pix_taken_next = pix_taken_reg;
        k_next         = k_reg;
        tap_vld_next   = 1'b0;
        tap_ok_next    = tap_ok_reg;
        tap_k_next     = tap_k_reg;
        div_step_next  = div_step_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        wsum_next      = wsum_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            prod[c]     = (2*CH_W)'(rd_data_reg[c*CH_W +: CH_W]) *
                          (2*CH_W)'(tap_weight(tap_k_reg));
            acc_next[c] = acc_reg[c];
            q_next[c]   = q_reg[c];
        end

        // multiply-accumulate of the tap read in the previous cycle
        if (tap_vld_reg && tap_ok_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                acc_next[c] = acc_reg[c] + SUM_W'(prod[c]);
            end
            wsum_next = wsum_reg + WSUM_W'(tap_weight(tap_k_reg));
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pix_taken_next = pix_ok;
                    if (pix_ok) begin
                        in_cnt_next = in_cnt_reg + CNT_W'(1);
                        in_ptr_next = (in_ptr_reg == ADDR_W'(RING_SIZE - 1)) ?
                                      '0 : in_ptr_reg + ADDR_W'(1);
                    end
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    acc_next[c] = '0;
                end
                wsum_next = '0;
                k_next    = '0;
                if (pix_taken_reg) begin
                    state_next = (lag >= (CNT_W'(w_eff_reg) + CNT_W'(2))) ? S_READ : S_IDLE;
                end else begin
                    state_next = ((in_cnt_reg >= total_reg) && (out_cnt_reg < in_cnt_reg)) ?
                                 S_READ : S_IDLE;
                end
            end
            S_READ: begin
                tap_vld_next = 1'b1;
                tap_ok_next  = row_ok && col_ok;
                tap_k_next   = k_reg;
                k_next       = k_reg + TAP_W'(1);
                if (k_reg == TAP_W'(TAPS - 1)) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                div_step_next = STEP_W'(DIV_STEPS - 1);
                state_next    = S_DIV;
            end
            S_DIV: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (acc_reg[c] >= dvs) begin
                        acc_next[c] = acc_reg[c] - dvs;
                        q_next[c]   = {q_reg[c][CH_W-2:0], 1'b1};
                    end else begin
                        q_next[c]   = {q_reg[c][CH_W-2:0], 1'b0};
                    end
                end
                div_step_next = div_step_reg - STEP_W'(1);
                if (div_step_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {q_reg[2], q_reg[1], q_reg[0]};
                    m_tlast_next  = out_last;
                    if (out_last) begin
                        in_cnt_next  = '0;
                        out_cnt_next = '0;
                        in_ptr_next  = '0;
                        out_ptr_next = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end else begin
                        out_cnt_next = out_cnt_reg + CNT_W'(1);
                        out_ptr_next = (out_ptr_reg == ADDR_W'(RING_SIZE - 1)) ?
                                       '0 : out_ptr_reg + ADDR_W'(1);
                        if (WIDTH_W'(out_col_reg) == (w_eff_reg - WIDTH_W'(1))) begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + ROW_W'(1);
                        end else begin
                            out_col_next = out_col_reg + COL_W'(1);
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // register write abandons the frame
        if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    w_eff_next = w_new;
                    total_next = CNT_W'(w_new) * CNT_W'(h_eff_reg);
                end
                REG_IMAGE_HEIGHT: begin
                    h_eff_next = h_new;
                    total_next = CNT_W'(w_eff_reg) * CNT_W'(h_new);
                end
                default: ;
            endcase
            in_cnt_next  = '0;
            out_cnt_next = '0;
            in_ptr_next  = '0;
            out_ptr_next = '0;
            out_col_next = '0;
            out_row_next = '0;
            tap_vld_next = 1'b0;
            state_next   = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            w_eff_reg     <= WIDTH_RESET;
            h_eff_reg     <= HEIGHT_RESET;
            total_reg     <= CNT_W'(WIDTH_RESET) * CNT_W'(HEIGHT_RESET);
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            in_ptr_reg    <= '0;
            out_ptr_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pix_taken_reg <= 1'b0;
            k_reg         <= '0;
            tap_vld_reg   <= 1'b0;
            tap_ok_reg    <= 1'b0;
            tap_k_reg     <= '0;
            div_step_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            w_eff_reg     <= w_eff_next;
            h_eff_reg     <= h_eff_next;
            total_reg     <= total_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            in_ptr_reg    <= in_ptr_next;
            out_ptr_reg   <= out_ptr_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pix_taken_reg <= pix_taken_next;
            k_reg         <= k_next;
            tap_vld_reg   <= tap_vld_next;
            tap_ok_reg    <= tap_ok_next;
            tap_k_reg     <= tap_k_next;
            div_step_reg  <= div_step_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc_reg[c] <= acc_next[c];
            q_reg[c]   <= q_next[c];
        end
        wsum_reg    <= wsum_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // ring of two maximum-width rows plus four pixels
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[in_ptr_reg] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `GB3_ASSERT_NOW(a_out_behind_in, aclk, aresetn, 1'b1,
        out_cnt_reg <= in_cnt_reg, "result position ran ahead of input position")
    `GB3_ASSERT_NOW(a_in_within_frame, aclk, aresetn, 1'b1,
        in_cnt_reg <= total_reg, "input position beyond frame size")
    `GB3_ASSERT_NOW(a_center_used, aclk, aresetn, state_reg == S_DIV,
        wsum_reg >= WSUM_W'(W_CENTER), "weight sum misses the center tap")
    `GB3_ASSERT_NOW(a_rem_below_div, aclk, aresetn, state_reg == S_OUT,
        (acc_reg[0] < SUM_W'(wsum_reg)) && (acc_reg[1] < SUM_W'(wsum_reg)) &&
        (acc_reg[2] < SUM_W'(wsum_reg)), "division left remainder too large")
    `GB3_ASSERT_NEXT(a_frame_end_clears, aclk, aresetn,
        (state_reg == S_OUT) && out_free && out_last,
        (in_cnt_reg == '0) && (out_cnt_reg == '0), "counters not cleared at frame end")

endmodule

### dv/gaussian_blur_3x3_border_renorm_check.sv
// Checker for the 3x3 blur: watches the streams and the register port, predicts, compares.
module gaussian_blur_3x3_border_renorm_check
    import gb3_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [PIX_W-1:0]    s_tdata,   // in_red, in_green, in_blue
    input  logic                s_tuser,   // func
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [PIX_W-1:0]    m_tdata,   // out_red, out_green, out_blue
    input  logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [HEIGHT_W-1:0] cfg_wdata,
    output int                  mismatches,
    output int                  words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } blurred_t;

    blurred_t           blurred_q[$];
    blurred_t           got_word;
    blurred_t           want_word;
    logic [PIX_W-1:0]   frame_ring [RING_SIZE];
    logic [WIDTH_W-1:0] width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    int unsigned        in_count;
    int unsigned        out_count;
    int unsigned        out_col;
    int unsigned        out_row;
    int                 errs = 0;

    assign mismatches = errs;

    task automatic note_mismatch(input string what);
        errs++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    task automatic clear_position();
        in_count  = 0;
        out_count = 0;
        out_col   = 0;
        out_row   = 0;
    endtask

    // one accepted input word; pushes the blurred pixel it completes, if any
    task automatic take_input_word(input logic f, input logic [PIX_W-1:0] d);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned wsum;
        int unsigned acc [NUM_CH];
        int          rr;
        int          cc;
        int unsigned k;
        logic [PIX_W-1:0] px;
        blurred_t    res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        total = w * h;
        if (f == FUNC_PIXEL && in_count < total) begin
            frame_ring[in_count % RING_SIZE] = d;
            in_count++;
            if (in_count - out_count < w + 2)
                return;
        end else if (in_count < total || out_count >= in_count) begin
            return;
        end
        wsum = 0;
        for (int ch = 0; ch < NUM_CH; ch++)
            acc[ch] = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = int'(out_row) + dr;
                cc = int'(out_col) + dc;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
                    px = frame_ring[(rr * int'(w) + cc) % RING_SIZE];
                    if (dr == 0 && dc == 0)
                        k = W_CENTER;
                    else if (dr == 0 || dc == 0)
                        k = W_EDGE;
                    else
                        k = W_CORNER;
                    for (int ch = 0; ch < NUM_CH; ch++)
                        acc[ch] += px[CH_W*ch +: CH_W] * k;
                    wsum += k;
                end
            end
        end
        res.red       = CH_W'(acc[0] / wsum);
        res.green     = CH_W'(acc[1] / wsum);
        res.blue      = CH_W'(acc[2] / wsum);
        res.frame_end = (out_count + 1 >= total);
        if (res.frame_end) begin
            clear_position();
        end else begin
            out_count++;
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        blurred_q.push_back(res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            clear_position();
            blurred_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_wdata[WIDTH_W-1:0];
                else
                    height_reg = cfg_wdata;
                clear_position();
            end
            if (s_tvalid && s_tready)
                take_input_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got_word = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast};
                if (blurred_q.size() == 0) begin
                    note_mismatch($sformatf("word %h last %b with none expected",
                                            m_tdata, m_tlast));
                end else begin
                    want_word = blurred_q.pop_front();
                    if (got_word.red !== want_word.red)
                        note_mismatch($sformatf("red %h, want %h",
                                                got_word.red, want_word.red));
                    if (got_word.green !== want_word.green)
                        note_mismatch($sformatf("green %h, want %h",
                                                got_word.green, want_word.green));
                    if (got_word.blue !== want_word.blue)
                        note_mismatch($sformatf("blue %h, want %h",
                                                got_word.blue, want_word.blue));
                    if (got_word.frame_end !== want_word.frame_end)
                        note_mismatch($sformatf("frame end %b, want %b",
                                                got_word.frame_end, want_word.frame_end));
                end
            end
        end
        words_owed <= blurred_q.size();
    end

endmodule

### dv/gaussian_blur_3x3_border_renorm_test.sv
// Top of the 3x3 blur testbench: clock, reset, frame stimulus and the verdict.
module gaussian_blur_3x3_border_renorm_test
    import gb3_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 660;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [PIX_W-1:0]    s_tdata   = '0;
    logic                s_tuser   = FUNC_PIXEL;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [PIX_W-1:0]    m_tdata;
    logic                m_tlast;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = REG_IMAGE_WIDTH;
    logic [HEIGHT_W-1:0] cfg_wdata = '0;

    int mismatches;
    int words_owed;
    int cycles     = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int fed        = 0;
    int cur_w      = 640;
    int cur_h      = 480;

    gaussian_blur_3x3_border_renorm uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gaussian_blur_3x3_border_renorm_check blur_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .words_owed (words_owed)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle  = 0;
                recv_stall = 0;
            end
            IDLE_SEND: begin
                send_idle  = 59;
                recv_stall = 0;
            end
            IDLE_RECV: begin
                send_idle  = 0;
                recv_stall = 59;
            end
            default: begin
                send_idle  = 11;
                recv_stall = 11;
            end
        endcase
    endtask

    task automatic push_word(input logic f, input logic [PIX_W-1:0] d);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_owed != 0);
    endtask

    // write both size registers once the block has gone quiet
    task automatic set_frame_size(input logic [HEIGHT_W-1:0] w, input logic [HEIGHT_W-1:0] h);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_w = (w[WIDTH_W-1:0] == 0) ? 1 :
                ((w[WIDTH_W-1:0] > MAX_WIDTH) ? MAX_WIDTH : int'(w[WIDTH_W-1:0]));
        cur_h = (h == 0) ? 1 : int'(h);
    endtask

    // npix below the frame size leaves the frame unfinished
    task automatic run_frame(input int npix, input bit pause);
        int total;
        int drain;
        total = cur_w * cur_h;
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(99) < 5)
                push_word(FUNC_FLUSH, PIX_W'($urandom));
            push_word(FUNC_PIXEL, PIX_W'($urandom));
            fed++;
            if (pause && i == npix / 2)
                wait_drained();
        end
        if (npix == total) begin
            drain = (total < cur_w + 1) ? total : cur_w + 1;
            for (int j = 0; j < drain; j++) begin
                push_word(($urandom_range(99) < 30) ? FUNC_PIXEL : FUNC_FLUSH,
                          PIX_W'($urandom));
                fed++;
            end
            if ($urandom_range(99) < 20)
                push_word(FUNC_FLUSH, PIX_W'($urandom));
        end
    endtask

    initial begin
        int                  frame_no;
        int                  total;
        int                  npix;
        int                  pick;
        bit                  abandoned;
        logic [HEIGHT_W-1:0] w_raw;
        logic [HEIGHT_W-1:0] h_raw;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_idle(IDLE_NONE);

        // 3x2 frame: extreme pixels, early flush, pixel past the end, stray flush
        set_frame_size(13'd3, 13'd2);
        push_word(FUNC_PIXEL, 24'h000000);
        push_word(FUNC_PIXEL, 24'hFFFFFF);
        push_word(FUNC_FLUSH, 24'hFFFFFF);
        push_word(FUNC_PIXEL, 24'hFF00FF);
        push_word(FUNC_PIXEL, 24'h00FF00);
        push_word(FUNC_PIXEL, 24'h0000FF);
        push_word(FUNC_PIXEL, 24'hFFFF00);
        push_word(FUNC_PIXEL, 24'hA5A5A5);
        push_word(FUNC_FLUSH, 24'h000000);
        push_word(FUNC_FLUSH, 24'h5A5A5A);
        push_word(FUNC_FLUSH, 24'h000000);
        push_word(FUNC_FLUSH, 24'h000000);

        // single-pixel frames, also with zero sizes
        set_frame_size(13'd1, 13'd1);
        push_word(FUNC_PIXEL, 24'hFFFFFF);
        push_word(FUNC_FLUSH, 24'h000000);
        set_frame_size(13'd0, 13'd0);
        push_word(FUNC_PIXEL, 24'h123456);
        push_word(FUNC_FLUSH, 24'h000000);

        // frame cut short by the next register write
        set_frame_size(13'd4, 13'd3);
        for (int i = 0; i < 8; i++)
            push_word(FUNC_PIXEL, PIX_W'($urandom));

        // extreme sizes
        set_idle(IDLE_BOTH);
        set_frame_size(13'd4095, 13'd1);
        run_frame(60, 1'b0);
        set_idle(IDLE_SEND);
        set_frame_size(13'd2, 13'd8191);
        run_frame(40, 1'b0);
        set_idle(IDLE_RECV);
        set_frame_size(13'd5, 13'd0);
        run_frame(5, 1'b1);

        fed       = 0;
        frame_no  = 0;
        abandoned = 1'b0;
        while (fed < RANDOM_ITEMS) begin
            set_idle(idle_mode_t'(frame_no % 4));
            frame_no++;
            if (abandoned || $urandom_range(99) >= 25) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    w_raw = HEIGHT_W'($urandom_range(12, 1));
                else if (pick < 90)
                    w_raw = HEIGHT_W'($urandom_range(64, 13));
                else
                    w_raw = HEIGHT_W'($urandom_range(1, 0));
                if ($urandom_range(3) == 0)
                    w_raw[HEIGHT_W-1] = 1'b1;   // above the width field, dropped
                pick = $urandom_range(99);
                if (pick < 85)
                    h_raw = HEIGHT_W'($urandom_range(6, 1));
                else if (pick < 95)
                    h_raw = HEIGHT_W'($urandom_range(12, 7));
                else
                    h_raw = '0;
                set_frame_size(w_raw, h_raw);
            end
            total     = cur_w * cur_h;
            abandoned = (total > 1) && ($urandom_range(99) < 15);
            npix      = abandoned ? int'($urandom_range(total - 1)) : total;
            run_frame(npix, $urandom_range(99) < 5);
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && words_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### gaussian_blur_3x3_border_renorm.f
+incdir+hw/rtl
hw/rtl/gb3_pkg.sv
hw/rtl/gaussian_blur_3x3_border_renorm.sv
dv/gaussian_blur_3x3_border_renorm_check.sv
dv/gaussian_blur_3x3_border_renorm_test.sv
